/* rtl/b32d_pkg.sv */
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types and the character lookup for the base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

	// width of the length field carried in a status result
	localparam int unsigned LEN_OUT_W = 16;
	// bytes produced by one full group
	localparam int unsigned GROUP_BYTES = 5;
	// job queue depth between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	// padding character
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// result kind codes on tuser
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// one looked-up character
	typedef struct packed {
		logic       invalid;
		logic [4:0] value;
	} sym_t;

	// work handed from front to back: all results caused by one character
	typedef struct packed {
		logic [2:0]                      nbytes;
		logic [GROUP_BYTES-1:0][7:0]     bytes;
		logic                            has_status;
		logic                            ok;
		logic [LEN_OUT_W-1:0]            length;
	} job_t;

	// map a raw character to its 5-bit symbol; invalid bytes give zero
	function automatic sym_t sym_lookup(input logic [7:0] c);
		sym_t s;
		begin
			s.invalid = 1'b0;
			s.value   = 5'd0;
			case (c) inside
				8'h30: s.value = 5'd14;
				8'h31: s.value = 5'd11;
				[8'h32:8'h37]: s.value = 5'(c - 8'h18);
				8'h38: s.value = 5'd1;
				PAD_CHAR: s.value = 5'd0;
				[8'h41:8'h5A]: s.value = 5'(c - 8'h41);
				[8'h61:8'h7A]: s.value = 5'(c - 8'h61);
				default: s.invalid = 1'b1;
			endcase
			return s;
		end
	endfunction

endpackage

/* rtl/b32d_front.sv */
// ----------------------------------------------------------------------------
// b32d_front
// Accepts characters, tracks group and validation state, and builds one job
// per character that causes results.
// ----------------------------------------------------------------------------
module b32d_front import b32d_pkg::*; #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       push,
	output job_t       push_job
);

	logic [4:0]             gv_q [8];
	logic [2:0]             pos_q;
	logic [3:0]             marks_q;
	logic                   stopped_q;
	logic                   pad_started_q;
	logic [2:0]             csp_q;
	logic                   err_q;
	logic [LENGTH_BITS-1:0] total_q;

	sym_t                   sym;
	logic                   is_pad;
	logic [2:0]             pos_n;
	logic [3:0]             marks_n;
	logic                   stopped_n;
	logic                   pad_started_n;
	logic [2:0]             csp_n;
	logic                   err_n;
	logic [LENGTH_BITS-1:0] total_n;
	logic [LENGTH_BITS:0]   sum;
	logic [2:0]             cnt;
	logic                   emit;
	logic [GROUP_BYTES-1:0][7:0] bytes;
	logic                   ok;

	assign sym    = sym_lookup(char_code);
	assign is_pad = (char_code == PAD_CHAR);

	// byte assembly from the stored group plus the current symbol
	always_comb begin
		bytes[0] = {gv_q[0], gv_q[1][4:2]};
		bytes[1] = {gv_q[1][1:0], gv_q[2], gv_q[3][4]};
		bytes[2] = {gv_q[3][3:0], gv_q[4][4:1]};
		bytes[3] = {gv_q[4][0], gv_q[5], gv_q[6][4:3]};
		bytes[4] = {gv_q[6][2:0], sym.value};
	end

	// next state for this character
	always_comb begin
		err_n         = err_q | sym.invalid;
		pad_started_n = pad_started_q;
		csp_n         = csp_q;
		marks_n       = marks_q;
		stopped_n     = stopped_q;
		total_n       = total_q;
		pos_n         = pos_q + 3'd1;
		emit          = 1'b0;
		cnt           = 3'd5;
		sum           = '0;

		// padding tracking
		if (pad_started_q) begin
			if (!is_pad) begin
				err_n = 1'b1;
			end
			if (csp_q != 3'd7) begin
				csp_n = csp_q + 3'd1;
			end
		end else if (is_pad) begin
			pad_started_n = 1'b1;
			csp_n         = 3'd1;
			if (!(pos_q inside {3'd2, 3'd4, 3'd5, 3'd7})) begin
				err_n = 1'b1;
			end
		end

		// pad position marks
		if (is_pad) begin
			case (pos_q)
				3'd2:    marks_n[0] = 1'b1;
				3'd4:    marks_n[1] = 1'b1;
				3'd5:    marks_n[2] = 1'b1;
				3'd7:    marks_n[3] = 1'b1;
				default: marks_n = marks_q | 4'd0;
			endcase
		end

		// group end: byte count, totals
		if (pos_q == 3'd7) begin
			if (marks_n[0])      cnt = 3'd1;
			else if (marks_n[1]) cnt = 3'd2;
			else if (marks_n[2]) cnt = 3'd3;
			else if (marks_n[3]) cnt = 3'd4;
			else                 cnt = 3'd5;
			if (!stopped_q) begin
				emit = 1'b1;
				if (cnt != 3'd5) begin
					stopped_n = 1'b1;
				end
				sum = {1'b0, total_q} + (LENGTH_BITS + 1)'(cnt);
				if (sum[LENGTH_BITS]) begin
					total_n = '1;
				end else begin
					total_n = sum[LENGTH_BITS-1:0];
				end
			end
			marks_n = 4'd0;
			pos_n   = 3'd0;
		end
	end

	// verdict for a status result
	assign ok = !err_n && (pos_n == 3'd0) && (!pad_started_n || (csp_n <= 3'd6));

	// job out
	always_comb begin
		push                = acc && (emit || last_char);
		push_job.nbytes     = emit ? cnt : 3'd0;
		push_job.bytes      = bytes;
		push_job.has_status = last_char;
		push_job.ok         = ok;
		push_job.length     = LEN_OUT_W'(total_n);
	end

	// control state, cleared at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= 3'd0;
			marks_q       <= 4'd0;
			stopped_q     <= 1'b0;
			pad_started_q <= 1'b0;
			csp_q         <= 3'd0;
			err_q         <= 1'b0;
			total_q       <= '0;
		end else if (acc) begin
			if (last_char) begin
				pos_q         <= 3'd0;
				marks_q       <= 4'd0;
				stopped_q     <= 1'b0;
				pad_started_q <= 1'b0;
				csp_q         <= 3'd0;
				err_q         <= 1'b0;
				total_q       <= '0;
			end else begin
				pos_q         <= pos_n;
				marks_q       <= marks_n;
				stopped_q     <= stopped_n;
				pad_started_q <= pad_started_n;
				csp_q         <= csp_n;
				err_q         <= err_n;
				total_q       <= total_n;
			end
		end
	end

	// group symbol store, every slot written before it is read
	always_ff @(posedge clk) begin
		if (acc) begin
			gv_q[pos_q] <= sym.value;
		end
	end

endmodule

/* rtl/b32d_fifo.sv */
// ----------------------------------------------------------------------------
// b32d_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b32d_fifo import b32d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t head_job
);

	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(QDEPTH));
	assign avail    = (count_q != '0);
	assign head_job = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// fill count never exceeds the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("job queue over depth");

	// pop only when something is held
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail)
		else $error("job queue popped while empty");

endmodule

/* rtl/b32d_back.sv */
// ----------------------------------------------------------------------------
// b32d_back
// Takes jobs from the queue and sends their results one transfer at a time.
// ----------------------------------------------------------------------------
module b32d_back import b32d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        avail,
	input  job_t        head_job,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);

	job_t       job_q;
	logic       busy_q;
	logic [2:0] idx_q;

	logic [2:0] total;
	logic       is_status;
	logic       take;
	logic [7:0] data;

	assign total     = job_q.nbytes + {2'b00, job_q.has_status};
	assign is_status = (idx_q == job_q.nbytes);
	assign take      = busy_q && m_axis_tready;
	assign pop       = avail && (!busy_q || (take && m_axis_tlast));

	// byte select
	always_comb begin
		case (idx_q)
			3'd0:    data = job_q.bytes[0];
			3'd1:    data = job_q.bytes[1];
			3'd2:    data = job_q.bytes[2];
			3'd3:    data = job_q.bytes[3];
			3'd4:    data = job_q.bytes[4];
			default: data = 8'd0;
		endcase
	end

	// result fields
	always_comb begin
		m_axis_tvalid = busy_q;
		m_axis_tlast  = (idx_q == total - 3'd1);
		if (is_status) begin
			m_axis_tuser = KIND_STATUS;
			m_axis_tdata = {7'd0, job_q.length, job_q.ok, 8'd0};
		end else begin
			m_axis_tuser = KIND_DATA;
			m_axis_tdata = {7'd0, LEN_OUT_W'(0), 1'b0, data};
		end
	end

	// job register and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (take) begin
			if (m_axis_tlast) begin
				busy_q <= 1'b0;
				idx_q  <= 3'd0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	// a status result always closes its job
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("status result not marked last");

	// index stays inside the job
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < total))
		else $error("result index past end of job");

endmodule

/* rtl/base32_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base32_stream_decoder
// Streaming base32 decoder with validation: one character per transfer in,
// decoded bytes and an end-of-string status out.
//
//  channel   dir  tdata                               tuser       tlast
//  s_axis    in   [7:0] char_code                     -           last_char
//  m_axis    out  [7:0] data_byte, [8] string_ok,     kind        final_result
//                 [24:9] decoded_length
//
// One character is taken per cycle while the job queue has room. The back
// sends one result per cycle while the receiver is ready, up to six for the
// eighth character of a group that also ends the string; a four-entry job
// queue absorbs that burst. Input stalls only when the job queue is full.
// Reset clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
module base32_stream_decoder import b32d_pkg::*; #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [8] string_ok, [24:9] decoded_length
	output logic        m_axis_tuser,   // [0] kind
	output logic        m_axis_tlast
);

	logic acc;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	logic avail;
	job_t head_job;

	assign s_axis_tready = !full;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// character front end
	b32d_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.char_code(s_axis_tdata),
		.last_char(s_axis_tlast),
		.push     (push),
		.push_job (push_job)
	);

	// job queue
	b32d_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (full),
		.pop     (pop),
		.avail   (avail),
		.head_job(head_job)
	);

	// result back end
	b32d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (avail),
		.head_job     (head_job),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

/* dv/b32d_stream_checker.sv */
// ----------------------------------------------------------------------------
// b32d_stream_checker
// Watches both stream channels of the base32 decoder, predicts the decoded
// bytes and the end-of-string status for every accepted character, and
// compares each output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module b32d_stream_checker import b32d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [7:0] data_byte, [8] string_ok, [24:9] decoded_length
	input  logic        m_axis_tuser,   // [0] kind
	input  logic        m_axis_tlast,
	output int          errors,
	output int          outstanding
);

	// one predicted output transfer
	typedef struct packed {
		logic                 kind;
		logic [7:0]           data;
		logic                 ok;
		logic [LEN_OUT_W-1:0] len;
		logic                 fin;
	} dec_result_t;

	dec_result_t decode_queue[$];

	// decoder state mirror
	logic [4:0]           grp_val [8];
	logic [2:0]           grp_pos;
	logic [3:0]           pad_mk;
	logic                 stopped;
	logic                 pad_seen;
	logic [2:0]           since_pad;
	logic                 err_flag;
	logic [LEN_OUT_W-1:0] byte_cnt;

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	// character to 5-bit symbol, digits 0/1/8 read as O/L/B
	function automatic sym_t char_symbol(input logic [7:0] c);
		sym_t s;
		s.invalid = 1'b0;
		s.value   = 5'd0;
		if (c >= "A" && c <= "Z") begin
			s.value = 5'(c - "A");
		end else if (c >= "a" && c <= "z") begin
			s.value = 5'(c - "a");
		end else if (c >= "2" && c <= "7") begin
			s.value = 5'(c - "2") + 5'd26;
		end else if (c == "0") begin
			s.value = 5'd14;
		end else if (c == "1") begin
			s.value = 5'd11;
		end else if (c == "8") begin
			s.value = 5'd1;
		end else if (c != PAD_CHAR) begin
			s.invalid = 1'b1;
		end
		return s;
	endfunction

	task automatic clear_decoder();
		int i;
		for (i = 0; i < 8; i++) grp_val[i] = 5'd0;
		grp_pos   = 3'd0;
		pad_mk    = 4'd0;
		stopped   = 1'b0;
		pad_seen  = 1'b0;
		since_pad = 3'd0;
		err_flag  = 1'b0;
		byte_cnt  = '0;
	endtask

	// advance the mirror by one character and queue what it produces
	task automatic predict_char(input logic [7:0] c, input logic lst);
		sym_t          s;
		logic [2:0]    pos;
		logic          is_pad;
		logic [39:0]   bits;
		int            nbytes;
		int            nres;
		int            i;
		logic [LEN_OUT_W:0] sum;
		dec_result_t   r;
		s      = char_symbol(c);
		pos    = grp_pos;
		is_pad = (c == PAD_CHAR);
		nbytes = 0;
		bits   = '0;

		// validation bookkeeping
		if (s.invalid) err_flag = 1'b1;
		if (pad_seen) begin
			if (!is_pad) err_flag = 1'b1;
			if (since_pad < 3'd7) since_pad = since_pad + 3'd1;
		end else if (is_pad) begin
			pad_seen  = 1'b1;
			since_pad = 3'd1;
			if (pos != 3'd2 && pos != 3'd4 && pos != 3'd5 && pos != 3'd7) err_flag = 1'b1;
		end

		grp_val[pos] = s.value;
		if (is_pad) begin
			case (pos)
				3'd2: pad_mk[0] = 1'b1;
				3'd4: pad_mk[1] = 1'b1;
				3'd5: pad_mk[2] = 1'b1;
				3'd7: pad_mk[3] = 1'b1;
				default: ;
			endcase
		end

		// group complete: 40 bits split into bytes, msb first
		if (pos == 3'd7) begin
			if (!stopped) begin
				if (pad_mk[0]) nbytes = 1;
				else if (pad_mk[1]) nbytes = 2;
				else if (pad_mk[2]) nbytes = 3;
				else if (pad_mk[3]) nbytes = 4;
				else nbytes = GROUP_BYTES;
				if (nbytes < GROUP_BYTES) stopped = 1'b1;
				sum = {1'b0, byte_cnt} + (LEN_OUT_W+1)'(nbytes);
				byte_cnt = sum[LEN_OUT_W] ? '1 : sum[LEN_OUT_W-1:0];
				bits = {grp_val[0], grp_val[1], grp_val[2], grp_val[3],
					grp_val[4], grp_val[5], grp_val[6], grp_val[7]};
			end
			pad_mk  = 4'd0;
			grp_pos = 3'd0;
		end else begin
			grp_pos = pos + 3'd1;
		end

		nres = nbytes + (lst ? 1 : 0);
		for (i = 0; i < nbytes; i++) begin
			r.kind = KIND_DATA;
			r.data = bits[39-8*i -: 8];
			r.ok   = 1'b0;
			r.len  = '0;
			r.fin  = (i == nres - 1);
			decode_queue.push_back(r);
		end

		// end of string: status, then back to a fresh string
		if (lst) begin
			r.kind = KIND_STATUS;
			r.data = 8'd0;
			r.ok   = !err_flag && grp_pos == 3'd0 && (!pad_seen || since_pad <= 3'd6);
			r.len  = byte_cnt;
			r.fin  = 1'b1;
			decode_queue.push_back(r);
			clear_decoder();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// compare output transfers first, then predict from the input transfer
	always @(posedge clk or negedge arst_n) begin : watch
		dec_result_t want;
		if (!arst_n) begin
			clear_decoder();
			decode_queue.delete();
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (decode_queue.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, 32'd0);
				end else begin
					want = decode_queue.pop_front();
					if (m_axis_tuser !== want.kind)
						report_mismatch("kind", m_axis_tuser, want.kind);
					if (m_axis_tdata[7:0] !== want.data)
						report_mismatch("data_byte", m_axis_tdata[7:0], want.data);
					if (m_axis_tdata[8] !== want.ok)
						report_mismatch("string_ok", m_axis_tdata[8], want.ok);
					if (m_axis_tdata[24:9] !== want.len)
						report_mismatch("decoded_length", m_axis_tdata[24:9], want.len);
					if (m_axis_tdata[31:25] !== 7'd0)
						report_mismatch("tdata fill bits", m_axis_tdata[31:25], 32'd0);
					if (m_axis_tlast !== want.fin)
						report_mismatch("final_result", m_axis_tlast, want.fin);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_char(s_axis_tdata, s_axis_tlast);
			outstanding = decode_queue.size();
		end
	end

endmodule

/* dv/tb_base32_stream_decoder.sv */
// ----------------------------------------------------------------------------
// tb_base32_stream_decoder
// Feeds the base32 decoder directed strings and random encoded strings
// (well-formed, broken and noise) under three idling patterns; a checker
// beside the block predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module tb_base32_stream_decoder import b32d_pkg::*;;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] char_code
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // [7:0] data_byte, [8] string_ok, [24:9] decoded_length
	logic        m_axis_tuser;           // [0] kind
	logic        m_axis_tlast;

	int          errors;
	int          outstanding;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          chars_sent    = 0;
	logic [7:0]  char_buf[$];

	base32_stream_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	b32d_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// run limit
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// one character transfer, with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] c, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		chars_sent++;
	endtask

	task automatic send_buf();
		int i;
		for (i = 0; i < char_buf.size(); i++)
			send_char(char_buf[i], i == char_buf.size() - 1);
	endtask

	task automatic send_text(input string txt);
		int i;
		char_buf.delete();
		for (i = 0; i < txt.len(); i++) char_buf.push_back(txt[i]);
		send_buf();
	endtask

	// any character of the alphabet, both cases and the digit aliases
	function automatic logic [7:0] alpha_char();
		logic [7:0] c;
		case ($urandom_range(3))
			0: c = "A" + 8'($urandom_range(25));
			1: c = "a" + 8'($urandom_range(25));
			2: c = "2" + 8'($urandom_range(5));
			default: begin
				case ($urandom_range(2))
					0: c = "0";
					1: c = "1";
					default: c = "8";
				endcase
			end
		endcase
		return c;
	endfunction

	// whole groups of random content, optionally padded at the end
	task automatic build_encoded(input bit force_pad);
		int ngroups;
		int pad_at;
		int i;
		char_buf.delete();
		ngroups = $urandom_range(4, 1);
		for (i = 0; i < ngroups * 8; i++) char_buf.push_back(alpha_char());
		if (force_pad || $urandom_range(1)) begin
			case ($urandom_range(3))
				0: pad_at = 2;
				1: pad_at = 4;
				2: pad_at = 5;
				default: pad_at = 7;
			endcase
			for (i = pad_at; i < 8; i++) char_buf[(ngroups - 1) * 8 + i] = PAD_CHAR;
		end
	endtask

	// damage a well-formed string in one of several ways
	task automatic build_broken();
		int i;
		int n;
		case ($urandom_range(4))
			0: begin
				build_encoded(1'b0);
				char_buf[$urandom_range(char_buf.size() - 1)] = 8'($urandom_range(255));
			end
			1: begin
				build_encoded(1'b0);
				n = $urandom_range(7, 1);
				if (n >= char_buf.size()) n = char_buf.size() - 1;
				for (i = 0; i < n; i++) void'(char_buf.pop_back());
			end
			2: begin
				// padded group followed by more groups
				build_encoded(1'b1);
				n = $urandom_range(2, 1) * 8;
				for (i = 0; i < n; i++) char_buf.push_back(alpha_char());
			end
			3: begin
				// pad run longer than a group allows
				build_encoded(1'b1);
				n = $urandom_range(8, 1);
				for (i = 0; i < n; i++) char_buf.push_back(PAD_CHAR);
			end
			default: begin
				// stray pad inside the data
				build_encoded(1'b0);
				char_buf[$urandom_range(char_buf.size() - 1)] = PAD_CHAR;
			end
		endcase
	endtask

	task automatic build_noise();
		int n;
		int i;
		char_buf.delete();
		n = $urandom_range(20, 1);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) char_buf.push_back(alpha_char());
			else char_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic send_random_string();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6) build_encoded(1'b0);
		else if (sel < 8) build_broken();
		else build_noise();
		send_buf();
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int phase;
		int phase_end;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 32;
		recv_idle_pct = 75;

		// digit aliases in one full group
		send_text("01823456");
		// two bytes, pad from group position four
		send_text("MzXw====");
		// null, all-ones and brace in a short invalid string
		char_buf.delete();
		char_buf.push_back(8'h00);
		char_buf.push_back(8'hFF);
		char_buf.push_back("{");
		send_buf();
		// lone pad at the start of a group
		send_text("=");

		phase_end = chars_sent;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 32; recv_idle_pct = 75; end
				1: begin send_idle_pct = 75; recv_idle_pct = 32; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			phase_end += 155;
			while (chars_sent < phase_end) send_random_string();
		end
		s_axis_tvalid <= 1'b0;

		// sample the checker away from the clock edge
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
